// ===== rtl/tga_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared types, register indexes and constants of the TGA pixel decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

   localparam int MAX_DIM_DEFAULT       = 4096;
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH           = 4;
   localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W           = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DEPTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_VERTICAL = 3'd4;

   localparam logic [1:0] DEPTH_16 = 2'd0;
   localparam logic [1:0] DEPTH_24 = 2'd1;

   localparam int MODE_RLE_BIT     = 0;
   localparam int MODE_INDEXED_BIT = 1;

   localparam int          HDR_RUN_BIT  = 7;
   localparam logic [7:0]  HDR_CNT_MASK = 8'h7F;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
   localparam logic [15:0] MASK_RED16   = 16'h7C00;
   localparam logic [15:0] MASK_GREEN16 = 16'h03E0;
   localparam logic [15:0] MASK_BLUE16  = 16'h001F;

   typedef struct packed {
      logic [1:0]  decode_mode;
      logic [1:0]  pixel_depth;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        flip_vertical;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [7:0] pal_index;
      logic [7:0] pal_red;
      logic [7:0] pal_green;
      logic [7:0] pal_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] row_index;
      logic [11:0] col_start;
      logic [7:0]  span_length;
      logic        last_span;
      logic        image_done;
   } rsp_type;

   // One decoded pixel value and how many times it repeats.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] count;
   } cmd_type;

endpackage

// ===== rtl/tga_front.sv =====
// ----------------------------------------------------------------------------
// TGA decoder front end
// Accepts stream bytes and palette writes, parses packet headers, gathers
// pixel bytes and pushes one pixel command per raw pixel or run packet.
// ----------------------------------------------------------------------------
module tga_front import tga_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   input  logic [QUEUE_CNT_W-1:0] queue_count,
   output logic                   push,
   output cmd_type                push_data
);

   localparam int PAL_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [23:0] palette_mem [PALETTE_DEPTH];

   logic [7:0]  packet_left_ff, packet_left_in;
   logic        in_run_ff, in_run_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  bc_ff, bc_in;
   logic        p_valid_ff, p_valid_in;
   logic [31:0] p_value_ff, p_value_in;
   logic [7:0]  p_count_ff, p_count_in;
   logic [23:0] pal_q_ff;
   logic        pal_oor_ff;

   logic        accept;
   logic        data_acc;
   logic        pal_acc;
   logic        rle;
   logic        indexed;
   logic        header;
   logic [2:0]  bpp;
   logic [1:0]  bc_next;
   logic        complete;
   logic [31:0] asm_new;
   logic        pal_in_range;
   logic        pal_rd;

   assign req_stall = ({1'b0, queue_count} + {{QUEUE_CNT_W{1'b0}}, p_valid_ff})
                      >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign data_acc  = accept && !req_data.func;
   assign pal_acc   = accept && req_data.func;

   assign rle     = cfg.decode_mode[MODE_RLE_BIT];
   assign indexed = cfg.decode_mode[MODE_INDEXED_BIT];
   assign header  = rle && (packet_left_ff == 8'd0);

   always_comb begin
      if (indexed) begin
         bpp = 3'd1;
      end else begin
         case (cfg.pixel_depth)
            DEPTH_16: bpp = 3'd2;
            DEPTH_24: bpp = 3'd3;
            default:  bpp = 3'd4;
         endcase
      end
   end

   always_comb begin
      asm_new = asm_ff;
      for (int i = 0; i < 4; i++) begin
         if (bc_ff == 2'(i)) begin
            asm_new[8*i +: 8] = asm_ff[8*i +: 8] | req_data.data_byte;
         end
      end
   end

   assign bc_next  = bc_ff + 2'd1;
   assign complete = (bc_next == 2'd0) || ({1'b0, bc_next} >= bpp);

   always_comb begin
      packet_left_in = packet_left_ff;
      in_run_in      = in_run_ff;
      asm_in         = asm_ff;
      bc_in          = bc_ff;
      p_valid_in     = 1'b0;
      p_value_in     = asm_new;
      p_count_in     = 8'd1;
      if (data_acc) begin
         if (header) begin
            in_run_in      = req_data.data_byte[HDR_RUN_BIT];
            packet_left_in = (req_data.data_byte & HDR_CNT_MASK) + 8'd1;
            asm_in         = '0;
            bc_in          = 2'd0;
         end else if (complete) begin
            asm_in     = '0;
            bc_in      = 2'd0;
            p_valid_in = 1'b1;
            if (rle) begin
               if (in_run_ff) begin
                  p_count_in     = packet_left_ff;
                  packet_left_in = 8'd0;
               end else begin
                  packet_left_in = packet_left_ff - 8'd1;
               end
            end
         end else begin
            asm_in = asm_new;
            bc_in  = bc_next;
         end
      end
   end

   assign pal_in_range = 32'(req_data.pal_index) < PALETTE_DEPTH;
   assign pal_rd       = p_valid_in && indexed;

   always_ff @(posedge clock) begin
      if (pal_acc && pal_in_range) begin
         palette_mem[req_data.pal_index[PAL_W-1:0]] <=
            {req_data.pal_red, req_data.pal_green, req_data.pal_blue};
      end
      if (pal_rd) begin
         pal_q_ff   <= palette_mem[asm_new[PAL_W-1:0]];
         pal_oor_ff <= 32'(asm_new[7:0]) >= PALETTE_DEPTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_left_ff <= '0;
         in_run_ff      <= 1'b0;
         asm_ff         <= '0;
         bc_ff          <= '0;
         p_valid_ff     <= 1'b0;
      end else begin
         packet_left_ff <= packet_left_in;
         in_run_ff      <= in_run_in;
         asm_ff         <= asm_in;
         bc_ff          <= bc_in;
         p_valid_ff     <= p_valid_in;
      end
      if (p_valid_in) begin
         p_value_ff <= p_value_in;
         p_count_ff <= p_count_in;
      end
   end

   // Color expansion happens in the cycle after gathering, beside the palette read.
   always_comb begin
      push_data.count = p_count_ff;
      push_data.alpha = ALPHA_OPAQUE;
      if (indexed) begin
         push_data.red   = pal_oor_ff ? 8'd0 : pal_q_ff[23:16];
         push_data.green = pal_oor_ff ? 8'd0 : pal_q_ff[15:8];
         push_data.blue  = pal_oor_ff ? 8'd0 : pal_q_ff[7:0];
      end else if (cfg.pixel_depth == DEPTH_16) begin
         push_data.red   = {5'((p_value_ff[15:0] & MASK_RED16) >> 10), 3'b000};
         push_data.green = {5'((p_value_ff[15:0] & MASK_GREEN16) >> 5), 3'b000};
         push_data.blue  = {5'(p_value_ff[15:0] & MASK_BLUE16), 3'b000};
      end else begin
         push_data.red   = p_value_ff[23:16];
         push_data.green = p_value_ff[15:8];
         push_data.blue  = p_value_ff[7:0];
         if (cfg.pixel_depth != DEPTH_24) begin
            push_data.alpha = p_value_ff[31:24];
         end
      end
   end

   assign push = p_valid_ff;

endmodule

// ===== rtl/tga_queue.sv =====
// ----------------------------------------------------------------------------
// TGA decoder command queue
// Small first-in first-out buffer of pixel commands between the two halves.
// ----------------------------------------------------------------------------
module tga_queue import tga_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cmd_type                push_data,
   input  logic                   pop,
   output cmd_type                head,
   output logic                   not_empty,
   output logic [QUEUE_CNT_W-1:0] count
);

   cmd_type                slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign not_empty = count_ff != '0;
   assign do_pop    = pop && not_empty;
   assign do_push   = push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head      = slots[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
      end
   end

endmodule

// ===== rtl/tga_back.sv =====
// ----------------------------------------------------------------------------
// TGA decoder back end
// Places pixel commands in the image, splits runs at row ends and drives
// the registered span output.
// ----------------------------------------------------------------------------
module tga_back import tga_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type head,
   input  logic    not_empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int POS_W = $clog2(MAX_DIM);

   logic [POS_W-1:0] col_ff, row_ff;
   logic             finished_ff;
   logic             cur_valid_ff;
   cmd_type          cur_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic             col_wrap;
   logic [31:0]      col_eff, row_eff;
   logic             pre_finish;
   logic [31:0]      room;
   logic [7:0]       take;
   logic [31:0]      col_next;
   logic             span_wrap;
   logic             img_done;
   logic             last;
   logic             out_free;
   logic             drop;
   logic             produce;
   logic             cur_done;
   logic [31:0]      row_out;

   always_comb begin
      if (cfg.image_width < 13'd4) begin
         w_eff = DIM_W'(4);
      end else if (32'(cfg.image_width) > MAX_DIM) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = DIM_W'(cfg.image_width);
      end
      if (cfg.image_height < 13'd1) begin
         h_eff = DIM_W'(1);
      end else if (32'(cfg.image_height) > MAX_DIM) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = DIM_W'(cfg.image_height);
      end
   end

   // A narrower width written between images can leave the column past the row end.
   assign col_wrap   = 32'(col_ff) >= 32'(w_eff);
   assign col_eff    = col_wrap ? 32'd0 : 32'(col_ff);
   assign row_eff    = col_wrap ? 32'(row_ff) + 32'd1 : 32'(row_ff);
   assign pre_finish = col_wrap && (row_eff >= 32'(h_eff));

   assign room      = 32'(w_eff) - col_eff;
   assign take      = (room < 32'(cur_ff.count)) ? 8'(room) : cur_ff.count;
   assign col_next  = col_eff + 32'(take);
   assign span_wrap = col_next >= 32'(w_eff);
   assign img_done  = span_wrap && ((row_eff + 32'd1) >= 32'(h_eff));
   assign last      = (take == cur_ff.count) || img_done;
   assign row_out   = cfg.flip_vertical ? (32'(h_eff) - 32'd1 - row_eff) : row_eff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign drop     = cur_valid_ff && (finished_ff || pre_finish);
   assign produce  = cur_valid_ff && !finished_ff && !pre_finish && out_free;
   assign cur_done = drop || (produce && last);
   assign pop      = not_empty && (!cur_valid_ff || cur_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_valid_ff <= 1'b1;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (drop) begin
            finished_ff <= 1'b1;
         end else if (produce) begin
            col_ff <= span_wrap ? '0 : POS_W'(col_next);
            row_ff <= span_wrap ? POS_W'(row_eff + 32'd1) : POS_W'(row_eff);
            if (img_done) begin
               finished_ff <= 1'b1;
            end
         end
         if (produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end else if (produce) begin
         cur_ff.count <= cur_ff.count - take;
      end
      if (produce) begin
         rsp_data_ff.red         <= cur_ff.red;
         rsp_data_ff.green       <= cur_ff.green;
         rsp_data_ff.blue        <= cur_ff.blue;
         rsp_data_ff.alpha       <= cur_ff.alpha;
         rsp_data_ff.row_index   <= row_out[11:0];
         rsp_data_ff.col_start   <= col_eff[11:0];
         rsp_data_ff.span_length <= take;
         rsp_data_ff.last_span   <= last;
         rsp_data_ff.image_done  <= img_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/tga_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Decodes TGA image data (raw or run-length, truecolor or indexed) into
// spans of identical RGBA pixels placed by row and column.
// ----------------------------------------------------------------------------
// Usage. The request channel carries one transfer per stream byte (func 0)
// or per palette entry write (func 1). The response channel carries one
// transfer per span: a color, its row and start column, and its length.
// The user writes registers through the csr port only while the block is
// idle; the block itself does not enforce this.
// The byte that completes a pixel passes the front end's pixel register, a
// queue slot, the back end's command register and the response register
// before its first span appears. The front end takes one byte per cycle
// and the back end emits one span per cycle, each while not stalled; a run
// packet covering several row ends holds the back end for all its spans (up
// to 33 for a 128-pixel run) as the four-entry queue absorbs further pixels.
//
// Reset clears the packet parser, the pixel position, the queue and the
// response register; the palette holds whatever was last written. While
// rsp_stall is high, the pending span holds and the back end waits; the
// front end keeps taking bytes until the queue is full.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder import tga_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEFAULT,
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                cfg_ff;
   logic                   push;
   cmd_type                push_data;
   logic                   pop;
   cmd_type                head;
   logic                   not_empty;
   logic [QUEUE_CNT_W-1:0] queue_count;

   // Configuration registers. Writes to indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode   <= 2'd0;
         cfg_ff.pixel_depth   <= DEPTH_24;
         cfg_ff.image_width   <= 13'd4096;
         cfg_ff.image_height  <= 13'd4096;
         cfg_ff.flip_vertical <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DECODE_MODE:   cfg_ff.decode_mode   <= csr_data[1:0];
            CSR_PIXEL_DEPTH:   cfg_ff.pixel_depth   <= csr_data[1:0];
            CSR_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_data;
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_data;
            CSR_FLIP_VERTICAL: cfg_ff.flip_vertical <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The front end parses and gathers; it never needs the image position,
   // since everything after the final pixel is discarded by the back end.
   tga_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_count (queue_count),
      .push        (push),
      .push_data   (push_data)
   );

   tga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (queue_count)
   );

   // The back end owns the column and row counters and the end-of-image flag.
   tga_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/tga_checker.sv =====
// ----------------------------------------------------------------------------
// TGA decoder port checker
// Concurrent checks on the response port of the TGA pixel decoder.
// ----------------------------------------------------------------------------
module tga_checker import tga_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled span stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Spans cover between one and one run packet's worth of pixels.
   a_span_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.span_length != 8'd0) && (rsp_data.span_length <= 8'd128))
      else $error("span length out of range");

   // The span that completes the image is always the last one of its command.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.image_done |-> rsp_data.last_span)
      else $error("image done without last span");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind tga_rle_pixel_decoder tga_checker u_checker (.*);
